/* rtl/core/lsra_pkg.sv */
// Shared types and constants for the linear scan register assigner.
// Used by lsra_cell and linear_scan_register_assigner; depends on nothing.
`timescale 1ns / 1ps

package lsra_pkg;

   // Defaults for the top level parameters.
   localparam int NUM_SLOTS_DEF     = 12;
   localparam int MAX_VALUES_DEF    = 65536;
   localparam int POSITION_BITS_DEF = 24;

   // Fixed properties of the slot order and the item fields.
   localparam int GP_SLOTS       = 5;
   localparam int RESERVE_BITS   = 12;
   localparam int ID_BITS        = 16;
   localparam int SLOT_OUT_BITS  = 4;
   localparam int CLASS_BITS     = 2;
   localparam int SPILL_OUT_BITS = 16;

   localparam logic OP_ASSIGN = 1'b0;
   localparam logic OP_BEGIN  = 1'b1;

   localparam logic [CLASS_BITS-1:0] CLASS_GP = 2'd1;
   localparam logic [CLASS_BITS-1:0] CLASS_FP = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } lsra_state_type;

   // Control flags of the scan token as it walks the row of cells.
   typedef struct packed {
      logic tok;
      logic found;
      logic vic_valid;
   } lsra_flags_type;

   // Request attributes broadcast to every cell.
   typedef struct packed {
      logic [CLASS_BITS-1:0] value_class;
      logic                  call_live;
   } lsra_req_type;

endpackage

/* rtl/core/linear_scan_register_assigner.sv */
// Linear scan register assigner: top level with the request latch, the
// decision and the result register. Depends on lsra_pkg and lsra_cell.
`timescale 1ns / 1ps

// An assign item passes through these steps before the next item can be
// accepted: the launch register starts the scan token, the token walks the
// row of slot cells through one register per slot, one cell per cycle, and
// the end of the scan commits the choice and loads the result register. A
// begin item clears the table and the spill counter and gives no result. The
// result register lets the next item be accepted while a result still waits;
// a scan only stalls at its end if the previous result has not yet been taken.
module linear_scan_register_assigner #(
   parameter int NUM_SLOTS     = lsra_pkg::NUM_SLOTS_DEF,
   parameter int MAX_VALUES    = lsra_pkg::MAX_VALUES_DEF,
   parameter int POSITION_BITS = lsra_pkg::POSITION_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lsra_pkg::RESERVE_BITS-1:0]    csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_op,
   input  logic [lsra_pkg::ID_BITS-1:0]         req_value_id,
   input  logic [POSITION_BITS-1:0]             req_interval_start,
   input  logic [POSITION_BITS-1:0]             req_interval_end,
   input  logic [lsra_pkg::CLASS_BITS-1:0]      req_value_class,
   input  logic                                 req_call_live,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_in_register,
   output logic [lsra_pkg::SLOT_OUT_BITS-1:0]   rsp_assigned_slot,
   output logic [lsra_pkg::SPILL_OUT_BITS-1:0]  rsp_stack_slot,
   output logic                                 rsp_victim_spilled,
   output logic [lsra_pkg::ID_BITS-1:0]         rsp_victim_id
);
   import lsra_pkg::*;

   localparam int SLOT_W = $clog2(NUM_SLOTS);
   localparam int CNT_W  = $clog2(MAX_VALUES + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VALUES);

   lsra_state_type              state_ff, state_in;
   logic [RESERVE_BITS-1:0]     reserved_ff;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic                        launch_ff, launch_in;

   lsra_req_type                req_ff;
   logic [ID_BITS-1:0]          id_ff;
   logic [POSITION_BITS-1:0]    start_ff;
   logic [POSITION_BITS-1:0]    end_ff;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        in_reg_ff, in_reg_in;
   logic [SLOT_OUT_BITS-1:0]    slot_ff, slot_in;
   logic [SPILL_OUT_BITS-1:0]   spill_ff, spill_in;
   logic                        vic_sp_ff, vic_sp_in;
   logic [ID_BITS-1:0]          vic_id_ff, vic_id_in;

   logic                        accept;
   logic                        clear;
   logic                        finish;
   logic                        out_free;
   logic                        load_rsp;
   logic                        commit_en;
   logic [SLOT_W-1:0]           commit_idx;
   logic                        take_spill;

   lsra_flags_type              flags_c  [NUM_SLOTS+1];
   logic [SLOT_W-1:0]           chosen_c [NUM_SLOTS+1];
   logic [SLOT_W-1:0]           vidx_c   [NUM_SLOTS+1];
   logic [POSITION_BITS-1:0]    vend_c   [NUM_SLOTS+1];
   logic [ID_BITS-1:0]          vown_c   [NUM_SLOTS+1];
   logic [NUM_SLOTS-1:0]        res_bit;

   lsra_flags_type              last_flags;

   // The scan token enters the first cell with nothing found yet.
   assign flags_c[0]  = '{tok: launch_ff, found: 1'b0, vic_valid: 1'b0};
   assign chosen_c[0] = '0;
   assign vidx_c[0]   = '0;
   assign vend_c[0]   = '0;
   assign vown_c[0]   = '0;

   genvar gi;
   generate
      for (gi = 0; gi < NUM_SLOTS; gi++) begin : g_cell
         if (gi < RESERVE_BITS) begin : g_res
            assign res_bit[gi] = reserved_ff[gi];
         end else begin : g_nores
            assign res_bit[gi] = 1'b0;
         end

         lsra_cell #(
            .INDEX  (gi),
            .SLOT_W (SLOT_W),
            .POS_W  (POSITION_BITS)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .clear       (clear),
            .commit_en   (commit_en),
            .commit_idx  (commit_idx),
            .commit_id   (id_ff),
            .commit_end  (end_ff),
            .req         (req_ff),
            .start       (start_ff),
            .reserved    (res_bit[gi]),
            .flags_i     (flags_c[gi]),
            .chosen_i    (chosen_c[gi]),
            .vic_idx_i   (vidx_c[gi]),
            .vic_end_i   (vend_c[gi]),
            .vic_owner_i (vown_c[gi]),
            .flags_o     (flags_c[gi+1]),
            .chosen_o    (chosen_c[gi+1]),
            .vic_idx_o   (vidx_c[gi+1]),
            .vic_end_o   (vend_c[gi+1]),
            .vic_owner_o (vown_c[gi+1])
         );
      end
   endgenerate

   assign last_flags = flags_c[NUM_SLOTS];
   assign csr_ready  = 1'b1;
   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign clear      = accept && (req_op == OP_BEGIN);
   assign out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      launch_in    = 1'b0;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      in_reg_in    = in_reg_ff;
      slot_in      = slot_ff;
      spill_in     = spill_ff;
      vic_sp_in    = vic_sp_ff;
      vic_id_in    = vic_id_ff;
      commit_en    = 1'b0;
      commit_idx   = chosen_c[NUM_SLOTS];
      take_spill   = 1'b0;

      finish   = ((state_ff == ST_SCAN) && last_flags.tok) || (state_ff == ST_DONE);
      load_rsp = finish && out_free;

      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_op == OP_ASSIGN)) begin
               launch_in = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (finish) begin
               state_in = load_rsp ? ST_IDLE : ST_DONE;
            end
         end
         ST_DONE: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         in_reg_in    = 1'b0;
         slot_in      = '0;
         spill_in     = '0;
         vic_sp_in    = 1'b0;
         vic_id_in    = '0;
         if (last_flags.found) begin
            in_reg_in = 1'b1;
            slot_in   = SLOT_OUT_BITS'(chosen_c[NUM_SLOTS]);
            commit_en = 1'b1;
         end else if (last_flags.vic_valid && (vend_c[NUM_SLOTS] > end_ff)) begin
            // The busy owner that lives longest gives up its slot.
            in_reg_in  = 1'b1;
            slot_in    = SLOT_OUT_BITS'(vidx_c[NUM_SLOTS]);
            commit_idx = vidx_c[NUM_SLOTS];
            commit_en  = 1'b1;
            vic_sp_in  = 1'b1;
            vic_id_in  = vown_c[NUM_SLOTS];
            spill_in   = SPILL_OUT_BITS'(cnt_ff);
            take_spill = 1'b1;
         end else begin
            spill_in   = SPILL_OUT_BITS'(cnt_ff);
            take_spill = 1'b1;
         end
      end

      if (clear) begin
         cnt_in = '0;
      end else if (take_spill && (cnt_ff != CNT_MAX)) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         launch_ff    <= 1'b0;
         cnt_ff       <= '0;
         reserved_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         launch_ff    <= launch_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            reserved_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (req_op == OP_ASSIGN)) begin
         req_ff.value_class <= req_value_class;
         req_ff.call_live   <= req_call_live;
         id_ff              <= req_value_id;
         start_ff           <= req_interval_start;
         end_ff             <= req_interval_end;
      end
      in_reg_ff <= in_reg_in;
      slot_ff   <= slot_in;
      spill_ff  <= spill_in;
      vic_sp_ff <= vic_sp_in;
      vic_id_ff <= vic_id_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_in_register    = in_reg_ff;
   assign rsp_assigned_slot  = slot_ff;
   assign rsp_stack_slot     = spill_ff;
   assign rsp_victim_spilled = vic_sp_ff;
   assign rsp_victim_id      = vic_id_ff;

   a_commit_at_end: assert property (@(posedge clock) disable iff (reset)
      commit_en |-> ((state_ff == ST_DONE) || ((state_ff == ST_SCAN) && last_flags.tok)))
      else $error("slot committed outside the end of a scan");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_MAX)
      else $error("spill counter beyond its ceiling");

   a_launch_scan: assert property (@(posedge clock) disable iff (reset)
      launch_ff |-> (state_ff == ST_SCAN))
      else $error("scan token launched while not scanning");

   a_done_delivers: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DONE) && !rsp_valid_ff) |=> (rsp_valid_ff && (state_ff == ST_IDLE)))
      else $error("finished scan did not produce its result");

endmodule

/* rtl/core/lsra_cell.sv */
// One register slot of the assigner: busy flag, owner id and end position.
// Depends on lsra_pkg; instantiated in a row by linear_scan_register_assigner.
`timescale 1ns / 1ps

module lsra_cell #(
   parameter int INDEX  = 0,
   parameter int SLOT_W = 4,
   parameter int POS_W  = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            clear,
   input  logic                            commit_en,
   input  logic [SLOT_W-1:0]               commit_idx,
   input  logic [lsra_pkg::ID_BITS-1:0]    commit_id,
   input  logic [POS_W-1:0]                commit_end,
   input  lsra_pkg::lsra_req_type          req,
   input  logic [POS_W-1:0]                start,
   input  logic                            reserved,
   input  lsra_pkg::lsra_flags_type        flags_i,
   input  logic [SLOT_W-1:0]               chosen_i,
   input  logic [SLOT_W-1:0]               vic_idx_i,
   input  logic [POS_W-1:0]                vic_end_i,
   input  logic [lsra_pkg::ID_BITS-1:0]    vic_owner_i,
   output lsra_pkg::lsra_flags_type        flags_o,
   output logic [SLOT_W-1:0]               chosen_o,
   output logic [SLOT_W-1:0]               vic_idx_o,
   output logic [POS_W-1:0]                vic_end_o,
   output logic [lsra_pkg::ID_BITS-1:0]    vic_owner_o
);
   import lsra_pkg::*;

   localparam logic              IS_GP  = (INDEX < GP_SLOTS);
   localparam logic [SLOT_W-1:0] MY_IDX = SLOT_W'(INDEX);

   logic                 busy_ff;
   logic [ID_BITS-1:0]   owner_ff;
   logic [POS_W-1:0]     end_ff;

   lsra_flags_type       flags_ff, flags_in;
   logic [SLOT_W-1:0]    chosen_ff, chosen_in;
   logic [SLOT_W-1:0]    vic_idx_ff, vic_idx_in;
   logic [POS_W-1:0]     vic_end_ff, vic_end_in;
   logic [ID_BITS-1:0]   vic_owner_ff, vic_owner_in;

   logic                 eff_busy;
   logic                 allowed;
   logic                 hit;

   always_comb begin
      // A slot whose owner ended before the new start is free again.
      eff_busy = busy_ff && !(end_ff < start);

      if (reserved) begin
         allowed = 1'b0;
      end else if (req.value_class == CLASS_GP) begin
         allowed = IS_GP;
      end else if (req.value_class == CLASS_FP) begin
         allowed = !IS_GP && !req.call_live;
      end else begin
         allowed = 1'b0;
      end

      flags_in     = flags_i;
      chosen_in    = chosen_i;
      vic_idx_in   = vic_idx_i;
      vic_end_in   = vic_end_i;
      vic_owner_in = vic_owner_i;

      if (!flags_i.found && allowed && !eff_busy) begin
         flags_in.found = 1'b1;
         chosen_in      = MY_IDX;
      end else if (!flags_i.found && allowed && eff_busy &&
                   (!flags_i.vic_valid || end_ff > vic_end_i)) begin
         // Strictly later end only, so the earliest slot wins a tie.
         flags_in.vic_valid = 1'b1;
         vic_idx_in         = MY_IDX;
         vic_end_in         = end_ff;
         vic_owner_in       = owner_ff;
      end

      hit = commit_en && (commit_idx == MY_IDX);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         flags_ff <= '0;
      end else begin
         if (clear) begin
            busy_ff <= 1'b0;
         end else if (hit) begin
            busy_ff <= 1'b1;
         end else if (flags_i.tok) begin
            busy_ff <= eff_busy;
         end
         flags_ff.tok <= flags_i.tok;
         if (flags_i.tok) begin
            flags_ff.found     <= flags_in.found;
            flags_ff.vic_valid <= flags_in.vic_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (hit) begin
         owner_ff <= commit_id;
         end_ff   <= commit_end;
      end
      if (flags_i.tok) begin
         chosen_ff    <= chosen_in;
         vic_idx_ff   <= vic_idx_in;
         vic_end_ff   <= vic_end_in;
         vic_owner_ff <= vic_owner_in;
      end
   end

   assign flags_o     = flags_ff;
   assign chosen_o    = chosen_ff;
   assign vic_idx_o   = vic_idx_ff;
   assign vic_end_o   = vic_end_ff;
   assign vic_owner_o = vic_owner_ff;

endmodule
